[hw/rtl/igmp_query_responder_macros.svh]
// Assertion helpers for the checker file.
`ifndef IGMP_QUERY_RESPONDER_MACROS_SVH
`define IGMP_QUERY_RESPONDER_MACROS_SVH

// Clocked property, ignored while reset is high.
`define IQR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define IQR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/iqr_pkg.sv]
package iqr_pkg;

   localparam int REPLY_WORDS = 7;
   localparam int OFFSET_W    = $clog2(REPLY_WORDS);
   localparam int CSR_INDEX_W = 8;
   localparam int RAW_SUM_W   = 19;
   localparam int FOLD_SUM_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_BOARD_IP    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MCAST_GROUP = 8'd1;

   localparam logic [7:0]  PROTO_IGMP          = 8'h02;
   localparam logic [7:0]  IGMP_TYPE_QUERY     = 8'h11;
   localparam logic [7:0]  IGMP_TYPE_REPORT_V1 = 8'h12;
   localparam logic [7:0]  IGMP_TYPE_REPORT_V2 = 8'h16;
   localparam logic [7:0]  IP_VER_IHL          = 8'h45;
   localparam logic [15:0] REPLY_BYTES         = 16'd28;
   localparam logic [15:0] IP_FLAGS_DF         = 16'h4000;
   localparam logic [7:0]  IP_TTL              = 8'h01;

   localparam logic [OFFSET_W-1:0] LAST_OFFSET = OFFSET_W'(REPLY_WORDS - 1);

   // Header halves that never change: version/IHL+length, flags, TTL+protocol.
   localparam logic [RAW_SUM_W-1:0] IP_FIXED_SUM =
      RAW_SUM_W'({IP_VER_IHL, 8'h00}) + RAW_SUM_W'(REPLY_BYTES)
      + RAW_SUM_W'(IP_FLAGS_DF) + RAW_SUM_W'({IP_TTL, PROTO_IGMP});

   localparam logic [31:0] REPLY_WORD0 = {IP_VER_IHL, 8'h00, REPLY_BYTES};

   typedef struct packed {
      logic                 report_v2;
      logic [RAW_SUM_W-1:0] ip_sum;
      logic [RAW_SUM_W-1:0] igmp_sum;
   } raw_sum_type;

   typedef struct packed {
      logic                  report_v2;
      logic [FOLD_SUM_W-1:0] ip_sum;
      logic [FOLD_SUM_W-1:0] igmp_sum;
   } fold_sum_type;

   typedef struct packed {
      logic        report_v2;
      logic [15:0] ip_csum;
      logic [15:0] igmp_csum;
   } reply_type;

endpackage

[hw/rtl/iqr_match_sum.sv]
module iqr_match_sum
   import iqr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [7:0]  ip_protocol,
   input  logic [31:0] igmp_first_word,
   input  logic [31:0] igmp_second_word,
   input  logic [31:0] board_ip_address,
   input  logic [31:0] multicast_group,
   output logic        out_valid,
   input  logic        out_ready,
   output raw_sum_type out_data
);

   logic        valid_ff, valid_in;
   raw_sum_type data_ff, data_in;
   logic        match;
   logic [7:0]  rpt_type;

   // Filter: IGMP query for all groups or for our group.
   assign match = (ip_protocol == PROTO_IGMP)
                  && (igmp_first_word[31:24] == IGMP_TYPE_QUERY)
                  && ((igmp_second_word == 32'd0) || (igmp_second_word == multicast_group));

   assign rpt_type = (igmp_first_word[23:16] == 8'd0) ? IGMP_TYPE_REPORT_V1
                                                      : IGMP_TYPE_REPORT_V2;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in          = in_valid && match;
         data_in.report_v2 = (igmp_first_word[23:16] != 8'd0);
         data_in.igmp_sum  = RAW_SUM_W'({rpt_type, 8'h00})
                             + RAW_SUM_W'(multicast_group[31:16])
                             + RAW_SUM_W'(multicast_group[15:0]);
         data_in.ip_sum    = IP_FIXED_SUM
                             + RAW_SUM_W'(board_ip_address[31:16])
                             + RAW_SUM_W'(board_ip_address[15:0])
                             + RAW_SUM_W'(multicast_group[31:16])
                             + RAW_SUM_W'(multicast_group[15:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hw/rtl/iqr_csum_fold.sv]
module iqr_csum_fold
   import iqr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  raw_sum_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output reply_type   out_data
);

   logic         fold_valid_ff, fold_valid_in;
   fold_sum_type fold_ff, fold_in;
   logic         fold_ready;
   logic         cmp_valid_ff, cmp_valid_in;
   reply_type    cmp_ff, cmp_in;
   logic [15:0]  ip_final, igmp_final;

   // First fold: carries above bit 15 go back in once.
   assign fold_ready = !cmp_valid_ff || out_ready;
   assign in_ready   = !fold_valid_ff || fold_ready;

   always_comb begin
      fold_valid_in = fold_valid_ff;
      fold_in       = fold_ff;
      if (in_ready) begin
         fold_valid_in     = in_valid;
         fold_in.report_v2 = in_data.report_v2;
         fold_in.ip_sum    = FOLD_SUM_W'(in_data.ip_sum[15:0])
                             + FOLD_SUM_W'(in_data.ip_sum[RAW_SUM_W-1:16]);
         fold_in.igmp_sum  = FOLD_SUM_W'(in_data.igmp_sum[15:0])
                             + FOLD_SUM_W'(in_data.igmp_sum[RAW_SUM_W-1:16]);
      end
   end

   // Second fold cannot carry again; complement to get the checksum.
   assign ip_final   = fold_ff.ip_sum[15:0] + 16'(fold_ff.ip_sum[16]);
   assign igmp_final = fold_ff.igmp_sum[15:0] + 16'(fold_ff.igmp_sum[16]);

   always_comb begin
      cmp_valid_in = cmp_valid_ff;
      cmp_in       = cmp_ff;
      if (fold_ready) begin
         cmp_valid_in     = fold_valid_ff;
         cmp_in.report_v2 = fold_ff.report_v2;
         cmp_in.ip_csum   = ~ip_final;
         cmp_in.igmp_csum = ~igmp_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
         cmp_valid_ff  <= 1'b0;
      end else begin
         fold_valid_ff <= fold_valid_in;
         cmp_valid_ff  <= cmp_valid_in;
      end
      fold_ff <= fold_in;
      cmp_ff  <= cmp_in;
   end

   assign out_valid = cmp_valid_ff;
   assign out_data  = cmp_ff;

endmodule

[hw/rtl/iqr_reply_ser.sv]
module iqr_reply_ser
   import iqr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  reply_type           in_data,
   input  logic [31:0]         board_ip_address,
   input  logic [31:0]         multicast_group,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [OFFSET_W-1:0] rsp_word_offset,
   output logic [31:0]         rsp_reply_word,
   output logic                rsp_last_word
);

   logic                busy_ff, busy_in;
   logic [OFFSET_W-1:0] cnt_ff, cnt_in;
   reply_type           reply_ff, reply_in;
   logic                last;
   logic [7:0]          rpt_type;

   assign last     = (cnt_ff == LAST_OFFSET);
   assign in_ready = !busy_ff || (rsp_ready && last);

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      reply_in = reply_ff;
      if (busy_ff && rsp_ready && !last) begin
         cnt_in = cnt_ff + OFFSET_W'(1);
      end else if (in_ready) begin
         busy_in  = in_valid;
         cnt_in   = '0;
         reply_in = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      reply_ff <= reply_in;
   end

   assign rpt_type = reply_ff.report_v2 ? IGMP_TYPE_REPORT_V2 : IGMP_TYPE_REPORT_V1;

   always_comb begin
      case (cnt_ff)
         3'd0:    rsp_reply_word = REPLY_WORD0;
         3'd1:    rsp_reply_word = {16'h0000, IP_FLAGS_DF};
         3'd2:    rsp_reply_word = {IP_TTL, PROTO_IGMP, reply_ff.ip_csum};
         3'd3:    rsp_reply_word = board_ip_address;
         3'd4:    rsp_reply_word = multicast_group;
         3'd5:    rsp_reply_word = {rpt_type, 8'h00, reply_ff.igmp_csum};
         3'd6:    rsp_reply_word = multicast_group;
         default: rsp_reply_word = 32'd0;
      endcase
   end

   assign rsp_valid       = busy_ff;
   assign rsp_word_offset = cnt_ff;
   assign rsp_last_word   = last;

endmodule

[hw/rtl/igmp_query_responder.sv]
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    ip_protocol, igmp_first_word, igmp_second_word
// rsp_      out        rsp_valid/rsp_ready    word_offset, reply_word, last_word
// csr_      in         csr_valid/csr_ready    index, data
//
// A matching query becomes seven reply words, one per cycle while rsp_ready is
// high; the serializer takes the next reply as the last word is accepted. A
// request passes the match/sum, fold, complement and serializer registers before
// its first reply word. Other requests are accepted and dropped by the first stage.
// Reset is synchronous and clears all valid bits, the word counter and both CSRs.
// A stall on rsp_ready backs up every stage; nothing is lost or repeated.
module igmp_query_responder
   import iqr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_ip_protocol,
   input  logic [31:0]            req_igmp_first_word,
   input  logic [31:0]            req_igmp_second_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OFFSET_W-1:0]    rsp_word_offset,
   output logic [31:0]            rsp_reply_word,
   output logic                   rsp_last_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   logic [31:0] board_ip_ff, board_ip_in;
   logic [31:0] mcast_group_ff, mcast_group_in;

   logic        sum_valid, sum_ready;
   raw_sum_type sum_data;
   logic        fold_valid, fold_ready;
   reply_type   fold_data;

   // CSR writes always complete; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      board_ip_in    = board_ip_ff;
      mcast_group_in = mcast_group_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BOARD_IP:    board_ip_in    = csr_data;
            CSR_MCAST_GROUP: mcast_group_in = csr_data;
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         board_ip_ff    <= 32'd0;
         mcast_group_ff <= 32'd0;
      end else begin
         board_ip_ff    <= board_ip_in;
         mcast_group_ff <= mcast_group_in;
      end
   end

   // Stage 1: filter the query and form the raw ones'-complement sums.
   iqr_match_sum u_match_sum (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid),
      .in_ready         (req_ready),
      .ip_protocol      (req_ip_protocol),
      .igmp_first_word  (req_igmp_first_word),
      .igmp_second_word (req_igmp_second_word),
      .board_ip_address (board_ip_ff),
      .multicast_group  (mcast_group_ff),
      .out_valid        (sum_valid),
      .out_ready        (sum_ready),
      .out_data         (sum_data)
   );

   // Stages 2 and 3: fold carries and complement into both checksums.
   iqr_csum_fold u_csum_fold (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_data   (sum_data),
      .out_valid (fold_valid),
      .out_ready (fold_ready),
      .out_data  (fold_data)
   );

   // Stage 4: hold one reply and advance through its seven words.
   iqr_reply_ser u_reply_ser (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (fold_valid),
      .in_ready         (fold_ready),
      .in_data          (fold_data),
      .board_ip_address (board_ip_ff),
      .multicast_group  (mcast_group_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word_offset  (rsp_word_offset),
      .rsp_reply_word   (rsp_reply_word),
      .rsp_last_word    (rsp_last_word)
   );

endmodule

[hw/rtl/iqr_checker.sv]
`include "igmp_query_responder_macros.svh"

module iqr_checker
   import iqr_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [OFFSET_W-1:0]    rsp_word_offset,
   input logic [31:0]            rsp_reply_word,
   input logic                   rsp_last_word
);

   `IQR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word_offset) && $stable(rsp_reply_word), "reply word changed while stalled")

   `IQR_ASSERT(a_word_next, clock, reset, rsp_valid && rsp_ready && !rsp_last_word |=> rsp_valid && (rsp_word_offset == $past(rsp_word_offset) + OFFSET_W'(1)), "reply words not contiguous")

   `IQR_ASSERT(a_last_flag, clock, reset, rsp_valid |-> (rsp_last_word == (rsp_word_offset == LAST_OFFSET)), "last flag not on final word")

   `IQR_ASSERT(a_new_reply, clock, reset, rsp_valid && rsp_ready && rsp_last_word |=> !rsp_valid || (rsp_word_offset == '0), "reply does not restart at word 0")

   `IQR_ASSERT(a_word0, clock, reset, rsp_valid && (rsp_word_offset == '0) |-> (rsp_reply_word == REPLY_WORD0), "bad first header word")

endmodule

bind igmp_query_responder iqr_checker u_iqr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_word_offset (rsp_word_offset),
   .rsp_reply_word  (rsp_reply_word),
   .rsp_last_word   (rsp_last_word)
);
